>>> rtl/dcfl_pkg.sv
// ----------------------------------------------------------------------------
// dcfl_pkg
// Shared types and constants of the descriptor chain free list.
// ----------------------------------------------------------------------------
package dcfl_pkg;

    localparam int SLOT_W      = 6;
    localparam int COUNT_W     = 7;
    localparam int DEPTH       = 2 ** SLOT_W;
    localparam int MAX_ENTRIES = 64;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_SHORT = 2'd1,
        STATUS_ZERO  = 2'd2
    } status_t;

    // one descriptor table word
    typedef struct packed {
        logic              busy;
        logic              chained;
        logic [SLOT_W-1:0] link;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // controller -> datapath
    typedef struct packed {
        logic rebuild;
        logic start;
        logic read;
        logic step;
        logic refuse;
    } dcfl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic refuse;
        logic is_free;
        logic busy;
        logic chained;
        logic last_one;
        logic out_free;
    } dcfl_stat_t;

endpackage

>>> rtl/descriptor_chain_free_list.sv
// ----------------------------------------------------------------------------
// descriptor_chain_free_list
// Linked free list of queue descriptors with chain allocate and free.
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall): kind, chain_length, chain_head.
// An allocate pops chain_length descriptors from the free head and returns
// one response transaction per descriptor in chain order, last set on the
// final one. A zero length or one above the free count returns a single
// refusal response. A free walks the chain from chain_head while entries
// are busy, pushing each onto the free head, ends after an unchained one
// and returns one response carrying chain_head and the new free count.
// Response channel (rsp_valid / rsp_stall) comes from an output register.
// Config channel (cfg_valid / cfg_ready) writes ring_entries and rebuilds
// the list; it is ready only while no request is in flight.
// Sequence: a request is taken, then each descriptor takes a table read
// and then a table update. When the receiver stalls, the walk pauses on
// the entry whose response waits. Reset sets 64 entries, all free, linked
// in index order.
// ----------------------------------------------------------------------------
module descriptor_chain_free_list (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          kind,
    input  logic [dcfl_pkg::COUNT_W-1:0]  chain_length,
    input  logic [dcfl_pkg::SLOT_W-1:0]   chain_head,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [dcfl_pkg::SLOT_W-1:0]   slot,
    output logic                          last,
    output logic [1:0]                    status,
    output logic [dcfl_pkg::COUNT_W-1:0]  free_left,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dcfl_pkg::COUNT_W-1:0]  ring_entries
);
    import dcfl_pkg::*;

    dcfl_cmd_t  cmd;
    dcfl_stat_t stat;

    dcfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dcfl_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .ring_entries (ring_entries),
        .kind         (kind),
        .chain_length (chain_length),
        .chain_head   (chain_head),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .slot         (slot),
        .last         (last),
        .status       (status),
        .free_left    (free_left)
    );

endmodule

>>> rtl/dcfl_ram.sv
// ----------------------------------------------------------------------------
// dcfl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dcfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/dcfl_ctrl.sv
// ----------------------------------------------------------------------------
// dcfl_ctrl
// Sequencer: accepts one transaction, then alternates table read and update
// until the chain is done; a refused request goes to a refusal instead.
// ----------------------------------------------------------------------------
module dcfl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  dcfl_pkg::dcfl_stat_t stat,
    output dcfl_pkg::dcfl_cmd_t  cmd
);
    import dcfl_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_REFUSE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   idle;
    logic   need_emit;

    assign idle      = (state_reg == ST_IDLE);
    assign cfg_ready = idle;
    // a configuration write wins over a request in the same cycle
    assign req_stall = !idle || cfg_valid;

    // an update produces a result unless the free walk goes on
    assign need_emit = !stat.is_free || !stat.busy || !stat.chained;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.rebuild = idle && cfg_valid;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && !cfg_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = stat.refuse ? ST_REFUSE : ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!need_emit || stat.out_free)
                begin
                    cmd.step = 1'b1;
                    if (stat.is_free)
                    begin
                        state_next = need_emit ? ST_IDLE : ST_READ;
                    end
                    else
                    begin
                        state_next = stat.last_one ? ST_IDLE : ST_READ;
                    end
                end
            end
            ST_REFUSE:
            begin
                if (stat.out_free)
                begin
                    cmd.refuse = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_read_then_update: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> state_reg == ST_UPDATE)
        else $error("table read not followed by update");

    a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !cmd.rebuild)
        else $error("request and rebuild in the same cycle");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

endmodule

>>> rtl/dcfl_datapath.sv
// ----------------------------------------------------------------------------
// dcfl_datapath
// Descriptor table, free head and count, chain cursor and result register.
// ----------------------------------------------------------------------------
module dcfl_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dcfl_pkg::dcfl_cmd_t           cmd,
    output dcfl_pkg::dcfl_stat_t          stat,
    input  logic [dcfl_pkg::COUNT_W-1:0]  ring_entries,
    input  logic                          kind,
    input  logic [dcfl_pkg::COUNT_W-1:0]  chain_length,
    input  logic [dcfl_pkg::SLOT_W-1:0]   chain_head,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [dcfl_pkg::SLOT_W-1:0]   slot,
    output logic                          last,
    output logic [1:0]                    status,
    output logic [dcfl_pkg::COUNT_W-1:0]  free_left
);
    import dcfl_pkg::*;

    logic [COUNT_W-1:0] ring_reg, ring_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [SLOT_W-1:0]  head_reg, head_next;
    logic [DEPTH-1:0]   valid_reg, valid_next;
    logic               kind_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [SLOT_W-1:0]  cur_reg;
    logic [SLOT_W-1:0]  head_in_reg;
    status_t            refuse_code_reg;

    logic               rsp_valid_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               last_reg;
    status_t            status_reg;
    logic [COUNT_W-1:0] left_reg;

    logic [COUNT_W-1:0] ring_clamped;
    logic [COUNT_W-1:0] succ;
    logic [SLOT_W-1:0]  dflt_link;
    logic [ENTRY_W-1:0] rd_word;
    entry_t             rd_raw;
    entry_t             cur_entry;
    entry_t             wr_entry;
    logic               we;
    logic               out_free;
    logic               emit;
    logic [SLOT_W-1:0]  emit_slot;
    logic               emit_last;
    status_t            emit_status;
    logic [COUNT_W-1:0] emit_left;
    logic [COUNT_W-1:0] total_inc;

    // descriptor table, registered read
    dcfl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (cur_reg),
        .wdata (wr_entry),
        .re    (cmd.read),
        .raddr (cur_reg),
        .rdata (rd_word)
    );

    assign rd_raw = entry_t'(rd_word);

    // entries not written since the last rebuild read as the rebuilt list
    assign succ      = {1'b0, cur_reg} + COUNT_W'(1);
    assign dflt_link = (succ < ring_reg) ? succ[SLOT_W-1:0] : '0;

    always_comb
    begin
        if (valid_reg[cur_reg])
        begin
            cur_entry = rd_raw;
        end
        else
        begin
            cur_entry.busy    = 1'b0;
            cur_entry.chained = 1'b0;
            cur_entry.link    = dflt_link;
        end
    end

    always_comb
    begin
        priority if (ring_entries == '0)
        begin
            ring_clamped = COUNT_W'(1);
        end
        else if (ring_entries > COUNT_W'(MAX_ENTRIES))
        begin
            ring_clamped = COUNT_W'(MAX_ENTRIES);
        end
        else
        begin
            ring_clamped = ring_entries;
        end
    end

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign total_inc = (total_reg < ring_reg) ? total_reg + COUNT_W'(1) : total_reg;

    assign stat.refuse   = (kind == KIND_ALLOC)
                           && ((chain_length == '0) || (chain_length > total_reg));
    assign stat.is_free  = (kind_reg == KIND_FREE);
    assign stat.busy     = cur_entry.busy;
    assign stat.chained  = cur_entry.chained;
    assign stat.last_one = (count_reg == COUNT_W'(1));
    assign stat.out_free = out_free;

    always_comb
    begin
        ring_next   = ring_reg;
        total_next  = total_reg;
        head_next   = head_reg;
        valid_next  = valid_reg;
        we          = 1'b0;
        wr_entry    = cur_entry;
        emit        = 1'b0;
        emit_slot   = '0;
        emit_last   = 1'b1;
        emit_status = STATUS_OK;
        emit_left   = total_reg;

        if (cmd.rebuild)
        begin
            ring_next  = ring_clamped;
            total_next = ring_clamped;
            head_next  = '0;
            valid_next = '0;
        end

        if (cmd.start && !stat.refuse && (kind == KIND_ALLOC))
        begin
            total_next = total_reg - chain_length;
        end

        if (cmd.refuse)
        begin
            emit        = 1'b1;
            emit_status = refuse_code_reg;
        end

        if (cmd.step)
        begin
            if (kind_reg == KIND_ALLOC)
            begin
                we               = 1'b1;
                wr_entry.busy    = 1'b1;
                wr_entry.chained = !stat.last_one;
                valid_next[cur_reg] = 1'b1;
                emit             = 1'b1;
                emit_slot        = cur_reg;
                emit_last        = stat.last_one;
                if (stat.last_one)
                begin
                    head_next = cur_entry.link;
                end
            end
            else if (cur_entry.busy)
            begin
                we               = 1'b1;
                wr_entry.busy    = 1'b0;
                wr_entry.link    = head_reg;
                valid_next[cur_reg] = 1'b1;
                head_next        = cur_reg;
                total_next       = total_inc;
                emit             = !cur_entry.chained;
                emit_slot        = head_in_reg;
                emit_left        = total_inc;
            end
            else
            begin
                emit      = 1'b1;
                emit_slot = head_in_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg      <= COUNT_W'(MAX_ENTRIES);
            total_reg     <= COUNT_W'(MAX_ENTRIES);
            head_reg      <= '0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            ring_reg  <= ring_next;
            total_reg <= total_next;
            head_reg  <= head_next;
            valid_reg <= valid_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            kind_reg        <= kind;
            count_reg       <= chain_length;
            head_in_reg     <= chain_head;
            cur_reg         <= (kind == KIND_ALLOC) ? head_reg : chain_head;
            refuse_code_reg <= (chain_length == '0) ? STATUS_ZERO : STATUS_SHORT;
        end
        else if (cmd.step)
        begin
            count_reg <= count_reg - COUNT_W'(1);
            cur_reg   <= cur_entry.link;
        end
        if (emit)
        begin
            slot_reg   <= emit_slot;
            last_reg   <= emit_last;
            status_reg <= emit_status;
            left_reg   <= emit_left;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign slot      = slot_reg;
    assign last      = last_reg;
    assign status    = status_reg;
    assign free_left = left_reg;

    a_count_guard: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= ring_reg)
        else $error("free count above ring size");

    a_ring_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ring_reg != '0) && (ring_reg <= COUNT_W'(MAX_ENTRIES)))
        else $error("ring size out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result written over a pending transaction");

    a_alloc_debit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start && !stat.refuse && (kind == KIND_ALLOC)
        |=> total_reg == $past(total_reg) - $past(chain_length))
        else $error("allocation did not debit the free count");

endmodule

>>> verif/dcfl_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dcfl_checker
// Watches the request, response and ring size channels of the descriptor
// chain free list, keeps its own copy of the descriptor table, predicts the
// responses of every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module dcfl_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  logic                         req_stall,
    input  logic                         kind,
    input  logic [dcfl_pkg::COUNT_W-1:0] chain_length,
    input  logic [dcfl_pkg::SLOT_W-1:0]  chain_head,
    input  logic                         rsp_valid,
    input  logic                         rsp_stall,
    input  logic [dcfl_pkg::SLOT_W-1:0]  slot,
    input  logic                         last,
    input  logic [1:0]                   status,
    input  logic [dcfl_pkg::COUNT_W-1:0] free_left,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [dcfl_pkg::COUNT_W-1:0] ring_entries,
    output int                           mismatches,
    output int                           pending,
    output int                           checked
);
    import dcfl_pkg::*;

    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               last;
        status_t            status;
        logic [COUNT_W-1:0] free_left;
    } response_t;

    // shadow descriptor table
    logic [SLOT_W-1:0]  link_of   [DEPTH];
    logic               in_use    [DEPTH];
    logic               linked_on [DEPTH];
    logic [SLOT_W-1:0]  list_top;
    logic [COUNT_W-1:0] free_cnt;
    int                 ring_size;

    response_t due_responses[$];

    task report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH @%0t response %0d: %s", $time, checked, what);
        mismatches++;
    endtask

    task rebuild_list();
        for (int i = 0; i < DEPTH; i++)
        begin
            link_of[i]   = (i + 1 < ring_size) ? SLOT_W'(i + 1) : '0;
            in_use[i]    = 1'b0;
            linked_on[i] = 1'b0;
        end
        list_top = '0;
        free_cnt = COUNT_W'(ring_size);
    endtask

    task apply_ring_write(input logic [COUNT_W-1:0] value);
        ring_size = (value == 0) ? 1 : ((value > MAX_ENTRIES) ? MAX_ENTRIES : int'(value));
        rebuild_list();
    endtask

    task queue_response(input logic [SLOT_W-1:0] s, input logic l, input status_t st);
        response_t r;
        r.slot      = s;
        r.last      = l;
        r.status    = st;
        r.free_left = free_cnt;
        due_responses.push_back(r);
    endtask

    // Updates the shadow table for one request and queues its responses.
    task walk_request(input logic k, input logic [COUNT_W-1:0] len,
                      input logic [SLOT_W-1:0] head);
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] nxt;
        if (k == KIND_ALLOC)
        begin
            if (len == 0)
                queue_response('0, 1'b1, STATUS_ZERO);
            else if (len > free_cnt)
                queue_response('0, 1'b1, STATUS_SHORT);
            else
            begin
                cur      = list_top;
                free_cnt = free_cnt - len;
                for (int i = 0; i < int'(len); i++)
                begin
                    in_use[cur]    = 1'b1;
                    linked_on[cur] = (i + 1 != int'(len));
                    queue_response(cur, (i + 1 == int'(len)), STATUS_OK);
                    cur = link_of[cur];
                end
                list_top = cur;
            end
        end
        else
        begin
            cur = head;
            for (int i = 0; i < DEPTH && in_use[cur]; i++)
            begin
                nxt          = link_of[cur];
                in_use[cur]  = 1'b0;
                link_of[cur] = list_top;
                list_top     = cur;
                if (free_cnt < ring_size)
                    free_cnt++;
                // a descriptor without the chain mark ends the walk
                if (!linked_on[cur])
                    break;
                cur = nxt;
            end
            queue_response(head, 1'b1, STATUS_OK);
        end
    endtask

    task compare_response();
        response_t want;
        if (due_responses.size() == 0)
        begin
            report_mismatch($sformatf("unexpected response slot %0d last %0d status %0d",
                                      slot, last, status));
        end
        else
        begin
            want = due_responses.pop_front();
            if (slot !== want.slot)
                report_mismatch($sformatf("slot %0d, expected %0d", slot, want.slot));
            if (last !== want.last)
                report_mismatch($sformatf("last %0d, expected %0d", last, want.last));
            if (status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
            if (free_left !== want.free_left)
                report_mismatch($sformatf("free_left %0d, expected %0d",
                                          free_left, want.free_left));
        end
        checked++;
    endtask

    initial
    begin
        mismatches = 0;
        checked    = 0;
        pending    = 0;
        ring_size  = MAX_ENTRIES;
        rebuild_list();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size = MAX_ENTRIES;
            rebuild_list();
            due_responses.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_ring_write(ring_entries);
            if (req_valid && !req_stall)
                walk_request(kind, chain_length, chain_head);
            if (rsp_valid && !rsp_stall)
                compare_response();
            pending = due_responses.size();
        end
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the descriptor chain free list: directed corner
// requests, then random allocate and free traffic over several ring sizes
// with random gaps and response stalls; the checker does the comparison.
// ----------------------------------------------------------------------------
module testbench;
    import dcfl_pkg::*;

    localparam int LIMIT_CYCLES  = 3_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 55;
    localparam int RING_PLAN [9] = '{64, 8, 1, 37, 2, 16, 4, 64, 64};

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic               kind;
    logic [COUNT_W-1:0] chain_length;
    logic [SLOT_W-1:0]  chain_head;
    logic               rsp_valid;
    logic               rsp_stall;
    logic [SLOT_W-1:0]  slot;
    logic               last;
    logic [1:0]         status;
    logic [COUNT_W-1:0] free_left;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COUNT_W-1:0] ring_entries;

    int mismatches;
    int pending;
    int checked;

    bit                quiet;
    int                ring_now;
    int                allocs_sent;
    int                frees_sent;
    int                ring_writes;
    logic              kind_order[$];
    logic [SLOT_W-1:0] live_heads[$];
    bit                first_of_group;

    descriptor_chain_free_list dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .chain_length (chain_length),
        .chain_head   (chain_head),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .slot         (slot),
        .last         (last),
        .status       (status),
        .free_left    (free_left),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .ring_entries (ring_entries)
    );

    dcfl_checker scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .chain_length (chain_length),
        .chain_head   (chain_head),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .slot         (slot),
        .last         (last),
        .status       (status),
        .free_left    (free_left),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .ring_entries (ring_entries),
        .mismatches   (mismatches),
        .pending      (pending),
        .checked      (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("descriptor_chain_free_list verification failed");
        $finish;
    end

    // response stall bursts; none once the quiet tail starts
    initial
    begin
        int run;
        rsp_stall = 1'b0;
        forever
        begin
            run = $urandom_range(1, 30);
            if ($urandom_range(0, 7) == 0)
                run = $urandom_range(50, 200);
            rsp_stall = 1'b0;
            repeat (run) @(negedge clk);
            if (!quiet)
            begin
                rsp_stall = 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
        end
    end

    // harvest chain heads of successful allocations for well-formed frees
    initial first_of_group = 1'b1;
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall && kind_order.size() > 0)
        begin
            if (kind_order[0] == KIND_ALLOC && status == STATUS_OK && first_of_group)
                live_heads.push_back(slot);
            first_of_group = last;
            if (last)
                void'(kind_order.pop_front());
        end
    end

    task send_request(input logic k, input logic [COUNT_W-1:0] len,
                      input logic [SLOT_W-1:0] head);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        kind         = k;
        chain_length = len;
        chain_head   = head;
        req_valid    = 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        kind_order.push_back(k);
        if (k == KIND_ALLOC)
            allocs_sent++;
        else
            frees_sent++;
        @(negedge clk);
    endtask

    task write_ring(input logic [COUNT_W-1:0] value);
        req_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        ring_entries = value;
        cfg_valid    = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        live_heads.delete();
        ring_now = (value == 0) ? 1 : ((value > MAX_ENTRIES) ? MAX_ENTRIES : int'(value));
        ring_writes++;
    endtask

    task random_request();
        int                 r;
        int                 pick;
        logic [SLOT_W-1:0]  head;
        logic [COUNT_W-1:0] len;
        r = $urandom_range(0, 99);
        if (r < 45 && live_heads.size() > 0)
        begin
            pick = $urandom_range(0, live_heads.size() - 1);
            head = live_heads[pick];
            live_heads.delete(pick);
            send_request(KIND_FREE, COUNT_W'($urandom_range(0, MAX_ENTRIES)), head);
        end
        else if (r < 88)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                len = COUNT_W'($urandom_range(1, 8));
            else if (pick < 9)
                len = COUNT_W'($urandom_range(1, ring_now));
            else
                len = COUNT_W'($urandom_range(
                          (ring_now < MAX_ENTRIES) ? ring_now + 1 : MAX_ENTRIES,
                          MAX_ENTRIES));
            send_request(KIND_ALLOC, len, SLOT_W'($urandom_range(0, DEPTH - 1)));
        end
        else if (r < 93)
            send_request(KIND_ALLOC, '0, SLOT_W'($urandom_range(0, DEPTH - 1)));
        else
            send_request(KIND_FREE, COUNT_W'($urandom_range(0, MAX_ENTRIES)),
                         SLOT_W'($urandom_range(0, DEPTH - 1)));
    endtask

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        kind         = KIND_ALLOC;
        chain_length = '0;
        chain_head   = '0;
        cfg_valid    = 1'b0;
        ring_entries = COUNT_W'(MAX_ENTRIES);
        quiet        = 1'b0;
        ring_now     = MAX_ENTRIES;
        allocs_sent  = 0;
        frees_sent   = 0;
        ring_writes  = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // full ring after reset: zero length, whole ring, empty list, frees
        send_request(KIND_ALLOC, 7'd0,  6'd0);
        send_request(KIND_ALLOC, 7'd64, 6'd63);
        send_request(KIND_ALLOC, 7'd1,  6'd0);
        send_request(KIND_FREE,  7'd64, 6'd0);
        send_request(KIND_FREE,  7'd0,  6'd0);
        send_request(KIND_ALLOC, 7'd3,  6'd21);
        send_request(KIND_ALLOC, 7'd2,  6'd42);
        send_request(KIND_FREE,  7'd5,  6'd62);
        send_request(KIND_FREE,  7'd1,  6'd63);
        send_request(KIND_FREE,  7'd2,  6'd60);
        send_request(KIND_ALLOC, 7'd63, 6'd0);
        send_request(KIND_ALLOC, 7'd2,  6'd0);
        send_request(KIND_ALLOC, 7'd1,  6'd0);

        // zero size clamps to one entry; heads beyond the ring are idle
        write_ring(7'd0);
        send_request(KIND_ALLOC, 7'd1,  6'd0);
        send_request(KIND_ALLOC, 7'd1,  6'd0);
        send_request(KIND_FREE,  7'd0,  6'd0);
        send_request(KIND_FREE,  7'd0,  6'd63);
        send_request(KIND_FREE,  7'd0,  6'd1);

        // oversize clamps to the maximum
        write_ring(7'd127);
        send_request(KIND_ALLOC, 7'd7,  6'd0);

        // size that is not a power of two
        write_ring(7'd5);
        send_request(KIND_ALLOC, 7'd5,  6'd0);
        send_request(KIND_ALLOC, 7'd1,  6'd0);
        send_request(KIND_FREE,  7'd0,  6'd0);

        for (int p = 0; p < $size(RING_PLAN); p++)
        begin
            write_ring(COUNT_W'(RING_PLAN[p]));
            if (p == $size(RING_PLAN) - 1)
                quiet = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold off once until the block has drained completely
                if (p == 3 && n == 25)
                begin
                    req_valid = 1'b0;
                    while (pending != 0) @(negedge clk);
                end
                random_request();
            end
        end

        req_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Ran %0d requests (%0d allocate, %0d free) over %0d ring size writes",
                 allocs_sent + frees_sent, allocs_sent, frees_sent, ring_writes);
        $display("%0d responses compared against the shadow descriptor table", checked);
        if (mismatches == 0 && pending == 0)
            $display("descriptor_chain_free_list verification clean");
        else
            $display("descriptor_chain_free_list verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/dcfl_pkg.sv
rtl/dcfl_ram.sv
rtl/dcfl_ctrl.sv
rtl/dcfl_datapath.sv
rtl/descriptor_chain_free_list.sv
verif/dcfl_checker.sv
verif/testbench.sv
